[rtl/lbf_pkg.sv]
// Package for the log bloom filter engine: filter size, request codes,
// shared structs and index helper functions. No dependencies.

package lbf_pkg;

    // Filter geometry: a power of two from 64 to 65536 bits.
    localparam int FILTER_BITS  = 2048;
    localparam int FILTER_BYTES = FILTER_BITS / 8;
    localparam int IDX_W        = $clog2(FILTER_BITS);
    localparam int ADDR_W       = IDX_W - 3;

    // Request codes.
    localparam logic [2:0] REQ_ADD   = 3'd0;
    localparam logic [2:0] REQ_MERGE = 3'd1;
    localparam logic [2:0] REQ_MATCH = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_WRITE = 3'd4;

    typedef logic [ADDR_W-1:0] addr_t;

    // One cycle of memory traffic: a read port and a write port.
    typedef struct packed {
        logic       re;
        addr_t      raddr;
        logic       we;
        addr_t      waddr;
        logic [7:0] wdata;
    } mem_req_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] read_data;
        logic       match_ok;
        logic       match_done;
    } res_t;

    // Byte that holds the bit selected by a 16-bit hash pair.
    // (FILTER_BITS-1-idx)/8 is the upper part of the inverted index.
    function automatic addr_t bit_byte(input logic [15:0] pair);
        logic [IDX_W-1:0] inv;
        inv = ~pair[IDX_W-1:0];
        return inv[IDX_W-1:3];
    endfunction

    // One-hot mask of the bit selected by a hash pair within its byte.
    function automatic logic [7:0] bit_mask(input logic [15:0] pair);
        return 8'b0000_0001 << pair[2:0];
    endfunction

    // Byte index wrapped to the filter size.
    function automatic addr_t wrap_addr(input logic [7:0] idx);
        logic [15:0] ext;
        ext = {8'h00, idx};
        return ext[ADDR_W-1:0];
    endfunction

endpackage

[rtl/lbf_req_if.sv]
// Request channel of the log bloom filter engine: valid, ready and the
// request payload. Depends on nothing.

interface lbf_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [47:0] hash_prefix;
    logic [7:0]  byte_index;
    logic [7:0]  byte_value;
    logic        last_byte;

    modport source (
        output valid, req_type, hash_prefix, byte_index, byte_value, last_byte,
        input  ready
    );

    modport sink (
        input  valid, req_type, hash_prefix, byte_index, byte_value, last_byte,
        output ready
    );
endinterface

[rtl/lbf_res_if.sv]
// Result channel of the log bloom filter engine: valid, ready and the
// result payload. Depends on nothing.

interface lbf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       match_ok;
    logic       match_done;

    modport source (
        output valid, read_data, match_ok, match_done,
        input  ready
    );

    modport sink (
        input  valid, read_data, match_ok, match_done,
        output ready
    );
endinterface

[rtl/log_bloom_filter_engine.sv]
// Top level of the log bloom filter engine: sequencer, filter byte RAM and
// result buffer. Uses lbf_pkg, lbf_req_if, lbf_res_if, lbf_seq, lbf_ram, lbf_obuf.
//
//   channel  dir  beat
//   req      in   req_type, hash_prefix, byte_index, byte_value, last_byte
//   res      out  read_data, match_ok, match_done (one beat per request)
//
// An add does three read-modify-writes on the byte RAM (S_DATA, S_ADD1, S_ADD2);
// every other request does a RAM read, then its update and result in S_DATA.
// After reset a clearing pass writes zero to all FILTER_BYTES (256) bytes,
// one per cycle, while req.ready stays low.
// Results wait in a two-entry buffer; a stalled result side drops req.ready
// only once both entries are held.

module log_bloom_filter_engine import lbf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    lbf_req_if.sink   req,
    lbf_res_if.source res
);

    mem_req_t   mem_req;
    logic [7:0] mem_q;
    logic       obuf_full;
    logic       push;
    res_t       push_data;

    // Request sequencing and read-modify-write control.
    lbf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_req   (mem_req),
        .mem_q     (mem_q),
        .obuf_full (obuf_full),
        .push      (push),
        .push_data (push_data)
    );

    // Filter byte store.
    lbf_ram #(
        .DEPTH  (FILTER_BYTES),
        .DATA_W (8)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_q)
    );

    // Result buffering.
    lbf_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (obuf_full),
        .res       (res)
    );

endmodule

[rtl/lbf_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port,
// read-before-write on a same-address collision. No dependencies.

module lbf_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 8,
    parameter int AW     = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/lbf_seq.sv]
// Request sequencer: clearing pass, read-modify-write of filter bytes with
// write-to-read forwarding, and the running match flag. Uses lbf_pkg and
// lbf_req_if.

module lbf_seq import lbf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    lbf_req_if.sink    req,
    output mem_req_t   mem_req,
    input  logic [7:0] mem_q,
    input  logic       obuf_full,
    output logic       push,
    output res_t       push_data
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DATA  = 3'd2;
    localparam logic [2:0] S_ADD1  = 3'd3;
    localparam logic [2:0] S_ADD2  = 3'd4;

    logic [2:0]  state_reg, state_next;
    addr_t       clr_cnt_reg, clr_cnt_next;
    logic        running_reg, running_next;
    logic        fwd_hit_reg;
    logic [7:0]  fwd_data_reg;

    logic [2:0]  type_reg;
    logic [47:0] hash_reg;
    addr_t       addr_reg;
    logic [7:0]  val_reg;
    logic        last_reg;

    logic        accept;
    logic [7:0]  cur;
    logic        run_new;

    // A new request enters from idle or during the last write of an add.
    assign req.ready = ((state_reg == S_IDLE) || (state_reg == S_ADD2)) && !obuf_full;
    assign accept    = req.valid && req.ready;

    // Byte read last cycle, with the write of that same cycle forwarded.
    assign cur = fwd_hit_reg ? fwd_data_reg : mem_q;

    // Memory traffic, results and next state.
    always_comb
    begin
        mem_req      = '0;
        push         = 1'b0;
        push_data    = '0;
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        running_next = running_reg;
        run_new      = running_reg;

        if (accept)
        begin
            mem_req.re    = 1'b1;
            mem_req.raddr = (req.req_type == REQ_ADD) ? bit_byte(req.hash_prefix[47:32])
                                                      : wrap_addr(req.byte_index);
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_cnt_reg;
                mem_req.wdata = 8'h00;
                clr_cnt_next  = clr_cnt_reg + addr_t'(1);
                if (clr_cnt_reg == {ADDR_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DATA;
                end
            end
            S_DATA:
            begin
                push       = 1'b1;
                state_next = S_IDLE;
                case (type_reg)
                    REQ_ADD:
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = bit_byte(hash_reg[47:32]);
                        mem_req.wdata = cur | bit_mask(hash_reg[47:32]);
                        mem_req.re    = 1'b1;
                        mem_req.raddr = bit_byte(hash_reg[31:16]);
                        state_next    = S_ADD1;
                    end
                    REQ_MERGE:
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = addr_reg;
                        mem_req.wdata = cur | val_reg;
                    end
                    REQ_MATCH:
                    begin
                        if ((cur | val_reg) != cur)
                        begin
                            run_new = 1'b0;
                        end
                        push_data.match_ok   = run_new;
                        push_data.match_done = last_reg;
                        running_next         = last_reg ? 1'b1 : run_new;
                    end
                    REQ_READ:
                    begin
                        push_data.read_data = cur;
                    end
                    REQ_WRITE:
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = addr_reg;
                        mem_req.wdata = val_reg;
                    end
                    default:
                    begin
                        push_data = '0;
                    end
                endcase
            end
            S_ADD1:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = bit_byte(hash_reg[31:16]);
                mem_req.wdata = cur | bit_mask(hash_reg[31:16]);
                mem_req.re    = 1'b1;
                mem_req.raddr = bit_byte(hash_reg[15:0]);
                state_next    = S_ADD2;
            end
            S_ADD2:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = bit_byte(hash_reg[15:0]);
                mem_req.wdata = cur | bit_mask(hash_reg[15:0]);
                state_next    = accept ? S_DATA : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            running_reg <= 1'b1;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            running_reg <= running_next;
            fwd_hit_reg <= mem_req.re && mem_req.we && (mem_req.raddr == mem_req.waddr);
        end
    end

    // Request payload and forwarded write data.
    always_ff @(posedge clk)
    begin
        fwd_data_reg <= mem_req.wdata;
        if (accept)
        begin
            type_reg <= req.req_type;
            hash_reg <= req.hash_prefix;
            addr_reg <= wrap_addr(req.byte_index);
            val_reg  <= req.byte_value;
            last_reg <= req.last_byte;
        end
    end

endmodule

[rtl/lbf_obuf.sv]
// Two-entry result buffer that drives the result channel, so a new request
// can run while a result waits. Uses lbf_pkg and lbf_res_if.

module lbf_obuf import lbf_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  res_t     push_data,
    output logic     full,
    lbf_res_if.source res
);

    logic out_valid_reg;
    logic pend_valid_reg;
    res_t out_reg;
    res_t pend_reg;
    logic load;

    // The output stage takes a new beat when empty or being drained.
    assign load = !out_valid_reg || res.ready;
    assign full = pend_valid_reg;

    assign res.valid      = out_valid_reg;
    assign res.read_data  = out_reg.read_data;
    assign res.match_ok   = out_reg.match_ok;
    assign res.match_done = out_reg.match_done;

    // Occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg  <= pend_valid_reg || push;
            pend_valid_reg <= pend_valid_reg && push;
        end
        else if (push)
        begin
            pend_valid_reg <= 1'b1;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg  <= pend_valid_reg ? pend_reg : push_data;
            if (push)
            begin
                pend_reg <= push_data;
            end
        end
        else if (push)
        begin
            pend_reg <= push_data;
        end
    end

endmodule
